// File: hdl/icbs_pkg.sv
package icbs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int QUEUE_DEPTH = 2;
   localparam int LEN_W = 9;
   localparam int BYTE_W = 8;
   localparam int THR_W = 49;
   localparam int GEN_W = 48;
   localparam int HALF_W = 24;
   localparam int SEED_W = 32;

   // drand48 multiplier 0x5DEECE66D split at bit 24
   localparam logic [HALF_W-1:0] LCG_MULT_LO = 24'hECE66D;
   localparam logic [HALF_W-1:0] LCG_MULT_HI = 24'h0005DE;
   localparam logic [GEN_W-1:0] LCG_INC = 48'h00000000000B;
   localparam logic [15:0] SEED_LOW = 16'h330E;
   localparam logic [GEN_W-1:0] GEN_RESET = 48'h00000000330E;
   localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;

   typedef enum logic {
      REG_TABLE_LENGTH,
      REG_SEED_VALUE
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_DROP,
      OP_WRITE,
      OP_SAMPLE
   } op_type;

   typedef struct packed {
      op_type op;
      logic [BYTE_W-1:0] index;
      logic [THR_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic load;
      logic [SEED_W-1:0] seed;
   } seed_load_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_CROSS_A,
      ST_MUL_CROSS_B,
      ST_SEARCH,
      ST_OUT
   } back_state_type;

endpackage

// File: hdl/inverse_cdf_byte_sampler.sv
// Random byte source with a programmable distribution. An item with func 0 stores one
// ascending cumulative threshold (U1.48, 2^48 is 1.0) at entry_index and gives no result;
// an item with func 1 steps a 48-bit drand48 generator and returns the largest index
// below table_length whose threshold is at or below the new 48-bit fraction, or 0.
// Entries below the active length must be written before sampling. The back end writes
// a threshold as it dequeues the item. A sample goes through these steps in order: a
// dequeue, three passes through a shared 24x24 multiplier for the generator step, one
// table read per binary search step, and a load of the result register. A two-entry
// queue between the front end and the back end absorbs items while a sample is in
// progress. Writing seed_value loads the generator with {seed_value, 0x330E}; configure
// only while the block is idle.
module inverse_cdf_byte_sampler #(
   parameter int TABLE_DEPTH = icbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_entry_index,
   input  logic [48:0] req_threshold_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_sample_byte,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import icbs_pkg::*;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic csr_wr;
   reg_index_type csr_idx;
   seed_load_type seed_load;

   logic q_push, q_full, q_pop, q_valid;
   cmd_type q_cmd, q_head;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = reg_index_type'(csr_paddr[2]);

   always_comb begin
      len_in = len_ff;
      seed_in = seed_ff;
      seed_load.load = 1'b0;
      seed_load.seed = csr_pwdata;
      csr_prdata = '0;
      case (csr_idx)
         REG_TABLE_LENGTH: begin
            csr_prdata = 32'(len_ff);
            if (csr_wr) begin
               len_in = csr_pwdata[LEN_W-1:0];
            end
         end
         REG_SEED_VALUE: begin
            csr_prdata = seed_ff;
            if (csr_wr) begin
               seed_in = csr_pwdata;
               seed_load.load = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
         seed_ff <= '0;
      end else begin
         len_ff <= len_in;
         seed_ff <= seed_in;
      end
   end

   icbs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_entry_index     (req_entry_index),
      .req_threshold_value (req_threshold_value),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_cmd               (q_cmd)
   );

   icbs_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   icbs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .seed_load       (seed_load),
      .table_length    (len_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_byte (rsp_sample_byte)
   );

   // after an accepted item the queue is never empty in the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_valid)
      else $error("accepted item missing from queue");

   // the back end only dequeues an item that is there
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("dequeue from empty queue");

endmodule

// File: hdl/icbs_ram.sv
module icbs_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/icbs_fifo.sv
module icbs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  icbs_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output icbs_pkg::cmd_type head
);
   import icbs_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   cmd_type slots_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNTW'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/icbs_front.sv
module icbs_front #(
   parameter int TABLE_DEPTH = icbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [7:0]        req_entry_index,
   input  logic [48:0]       req_threshold_value,
   input  logic              q_full,
   output logic              q_push,
   output icbs_pkg::cmd_type q_cmd
);
   import icbs_pkg::*;

   logic in_range;

   assign in_range = (32'(req_entry_index) < TABLE_DEPTH);
   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full;

   always_comb begin
      q_cmd.index = req_entry_index;
      q_cmd.data = req_threshold_value;
      if (req_func) begin
         q_cmd.op = OP_SAMPLE;
      end else if (in_range) begin
         q_cmd.op = OP_WRITE;
      end else begin
         // write past the table end is dropped
         q_cmd.op = OP_DROP;
      end
   end

endmodule

// File: hdl/icbs_back.sv
module icbs_back #(
   parameter int TABLE_DEPTH = icbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  icbs_pkg::cmd_type        q_head,
   output logic                     q_pop,
   input  icbs_pkg::seed_load_type  seed_load,
   input  logic [8:0]               table_length,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_sample_byte
);
   import icbs_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = (IW + 1 > LEN_W) ? IW + 1 : LEN_W;

   back_state_type state_ff, state_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic [GEN_W-1:0] acc_ff, acc_in;
   logic [IW-1:0] lo_ff, lo_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic [IW-1:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   logic ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [THR_W-1:0] ram_wdata, ram_rdata;

   logic [HALF_W-1:0] mul_a, mul_b;
   logic [GEN_W-1:0] mul_p;

   logic [CW-1:0] len_ext;
   logic [IW-1:0] last_idx;
   logic [IW-1:0] mid_first, mid_up, mid_dn;
   logic hit, dn_done;

   icbs_ram #(.WIDTH(THR_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign mul_p = mul_a * mul_b;

   // effective length clamped to 1..TABLE_DEPTH, kept as last index
   assign len_ext = CW'(table_length);
   always_comb begin
      if (len_ext == '0) begin
         last_idx = '0;
      end else if (len_ext > CW'(TABLE_DEPTH)) begin
         last_idx = IW'(TABLE_DEPTH - 1);
      end else begin
         last_idx = IW'(len_ext - CW'(1));
      end
   end

   assign mid_first = IW'(({1'b0, last_idx} + (IW+1)'(1)) >> 1);
   assign mid_up = IW'(({1'b0, mid_ff} + {1'b0, hi_ff} + (IW+1)'(1)) >> 1);
   assign mid_dn = IW'(({1'b0, lo_ff} + {1'b0, mid_ff}) >> 1);
   assign hit = (ram_rdata <= {1'b0, gen_ff});
   assign dn_done = ((mid_ff - lo_ff) == IW'(1));

   always_comb begin
      state_in = state_ff;
      gen_in = gen_ff;
      acc_in = acc_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in = rsp_byte_ff;
      q_pop = 1'b0;
      ram_we = 1'b0;
      ram_waddr = IW'(q_head.index);
      ram_wdata = q_head.data;
      ram_raddr = mid_ff;
      mul_a = gen_ff[HALF_W-1:0];
      mul_b = LCG_MULT_LO;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_head.op)
                  OP_WRITE: begin
                     ram_we = 1'b1;
                  end
                  OP_SAMPLE: begin
                     state_in = ST_MUL_LO;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL_LO: begin
            acc_in = mul_p;
            state_in = ST_MUL_CROSS_A;
         end
         ST_MUL_CROSS_A: begin
            mul_a = gen_ff[GEN_W-1:HALF_W];
            acc_in = acc_ff + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
            state_in = ST_MUL_CROSS_B;
         end
         ST_MUL_CROSS_B: begin
            mul_b = LCG_MULT_HI;
            gen_in = acc_ff + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}} + LCG_INC;
            lo_in = '0;
            hi_in = last_idx;
            mid_in = mid_first;
            ram_raddr = mid_first;
            if (last_idx == '0) begin
               res_in = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               if (mid_ff == hi_ff) begin
                  res_in = mid_ff;
                  state_in = ST_OUT;
               end else begin
                  lo_in = mid_ff;
                  mid_in = mid_up;
                  ram_raddr = mid_up;
               end
            end else begin
               if (dn_done) begin
                  res_in = lo_ff;
                  state_in = ST_OUT;
               end else begin
                  hi_in = mid_ff - IW'(1);
                  mid_in = mid_dn;
                  ram_raddr = mid_dn;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in = BYTE_W'(res_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // the user must write the seed only while the block is idle; the block itself does not enforce it
      if (seed_load.load) begin
         gen_in = {seed_load.seed, SEED_LOW};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gen_ff <= GEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gen_ff <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      res_ff <= res_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_byte = rsp_byte_ff;

endmodule
